// ----- rtl/cidr_alm_pkg.sv -----
// shared types and constants for the cidr allow list matcher
package cidr_alm_pkg;

    // default table depth per address family
    localparam int ENTRIES_DEF = 16;

    localparam int ADDR_W  = 128;
    localparam int LEN_W   = 8;
    localparam int CNT_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int CIDX_W  = 1;

    localparam logic [CIDX_W-1:0] CFG_IPV4_COUNT = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_IPV6_COUNT = 1'd1;

    localparam logic       ACT_WRITE = 1'b0;
    localparam logic [1:0] FAM_IPV4  = 2'd0;
    localparam logic [1:0] FAM_IPV6  = 2'd1;

    localparam logic [LEN_W-1:0] IPV4_MAX_LEN = 8'd32;
    localparam logic [LEN_W-1:0] IPV6_MAX_LEN = 8'd128;

    typedef enum logic [1:0] {
        VERDICT_MATCH   = 2'd0,
        VERDICT_DENY    = 2'd1,
        VERDICT_NO_LIST = 2'd2,
        VERDICT_WRITE   = 2'd3
    } verdict_t;

    // one table entry, ipv4 entries sit in the top 32 prefix bits
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
    } entry_t;

    // table write request
    typedef struct packed {
        logic              v4_en;
        logic              v6_en;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
    } tbl_wr_t;

endpackage

// ----- rtl/cidr_alm_table.sv -----
// prefix tables for both families with registered read and per-entry valid bits
module cidr_alm_table
    import cidr_alm_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_wr_t          wr,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic             rd_v6,
    output entry_t           rd_entry
);

    logic [37:0]  v4_mem [ENTRIES];
    logic [135:0] v6_mem [ENTRIES];

    logic [ENTRIES-1:0] v4_vld_reg;
    logic [ENTRIES-1:0] v6_vld_reg;

    logic [37:0]  v4_rd_reg;
    logic [135:0] v6_rd_reg;
    logic         v4_rd_vld_reg;
    logic         v6_rd_vld_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.v4_en)
        begin
            v4_mem[wr_addr] <= {wr.prefix[ADDR_W-1 -: 32], wr.len[5:0]};
        end
        if (wr.v6_en)
        begin
            v6_mem[wr_addr] <= {wr.prefix, wr.len};
        end
        v4_rd_reg <= v4_mem[rd_addr];
        v6_rd_reg <= v6_mem[rd_addr];
    end

    // valid bits stand in for the all-zero reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_vld_reg    <= '0;
            v6_vld_reg    <= '0;
            v4_rd_vld_reg <= 1'b0;
            v6_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.v4_en)
            begin
                v4_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr.v6_en)
            begin
                v6_vld_reg[wr_addr] <= 1'b1;
            end
            v4_rd_vld_reg <= v4_vld_reg[rd_addr];
            v6_rd_vld_reg <= v6_vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        rd_entry = '0;
        if (rd_v6)
        begin
            if (v6_rd_vld_reg)
            begin
                rd_entry.prefix = v6_rd_reg[135:8];
                rd_entry.len    = v6_rd_reg[7:0];
            end
        end
        else
        begin
            if (v4_rd_vld_reg)
            begin
                rd_entry.prefix = {v4_rd_reg[37:6], 96'd0};
                rd_entry.len    = {2'd0, v4_rd_reg[5:0]};
            end
        end
    end

endmodule

// ----- rtl/cidr_alm_match.sv -----
// shared prefix compare unit: masked 128-bit equality on the leading len bits
module cidr_alm_match
    import cidr_alm_pkg::*;
(
    input  logic [ADDR_W-1:0] addr,
    input  entry_t            entry,
    output logic              hit
);

    logic [ADDR_W-1:0] mask;

    always_comb
    begin
        for (int j = 0; j < ADDR_W; j++)
        begin
            // bit counted from the top is kept when it lies inside the prefix
            mask[ADDR_W-1-j] = (LEN_W'(j) < entry.len);
        end
        hit = (((addr ^ entry.prefix) & mask) == '0);
    end

endmodule

// ----- rtl/cidr_allow_list_matcher.sv -----
// top level of the cidr allow list matcher: sequencer, config registers, result register
//
// Checks a client address against an IPv4 and an IPv6 allow list of CIDR prefixes and
// stores new prefixes. Every input transfer gives exactly one result transfer. A write
// item goes from ST_IDLE to ST_OUT, which hands its result to the output register; the
// next item can be taken once the block is back in ST_IDLE. A check of an unknown
// family or of a family whose entry count is zero also goes straight to ST_OUT. A check
// that scans passes through ST_SCAN, where it compares k entries before ST_OUT, with k
// the number of entries compared (1 up to min(count, ENTRIES)): a single compare unit
// looks at one entry per cycle, fed by the one registered read port of the prefix tables.
// A stalled result channel holds the result in ST_OUT until the output register is free.
// The block takes one item at a time; in_stall is high from the input transfer until the
// result is in the output register, and the output register may still hold an untaken
// result while the next item is taken. Entry counts are written through the cfg port
// (index 0 is the IPv4 count, 1 the IPv6 count, reset value 1); the user must write them
// only while the block is idle, which the block itself does not enforce. Counts above
// ENTRIES scan ENTRIES entries. After reset every entry reads as the catch-all prefix of
// length zero through per-entry valid bits, so no clearing pass is needed.
module cidr_allow_list_matcher
    import cidr_alm_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,

    // config write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]  cfg_data,

    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [1:0]        family,
    input  logic [SLOT_W-1:0] entry_index,
    input  logic [63:0]       address_high,
    input  logic [63:0]       address_low,
    input  logic [LEN_W-1:0]  prefix_length,

    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic              allowed,
    output logic [SLOT_W-1:0] match_index,
    output logic [1:0]        verdict
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LIM_W = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    // control state
    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  v4_cnt_reg,    v4_cnt_next;
    logic [CNT_W-1:0]  v6_cnt_reg,    v6_cnt_next;
    logic [IDX_W-1:0]  idx_reg,       idx_next;
    logic [IDX_W-1:0]  lim_reg,       lim_next;
    logic              v6_reg,        v6_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [ADDR_W-1:0] addr_reg,      addr_next;
    logic              res_allow_reg, res_allow_next;
    logic [SLOT_W-1:0] res_idx_reg,   res_idx_next;
    verdict_t          res_verd_reg,  res_verd_next;
    logic              allowed_reg,   allowed_next;
    logic [SLOT_W-1:0] match_reg,     match_next;
    verdict_t          verdict_reg,   verdict_next;

    logic              in_xfer;
    logic              out_free;
    logic [CNT_W-1:0]  cnt_sel;
    logic [LIM_W-1:0]  lim_wide;
    logic [LEN_W-1:0]  len_clamped;
    logic              slot_ok;
    tbl_wr_t           tbl_wr;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_entry;
    logic              hit;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign allowed     = allowed_reg;
    assign match_index = match_reg;
    assign verdict     = verdict_reg;

    // entry writes happen at the input transfer itself
    assign slot_ok     = (32'(entry_index) < ENTRIES);
    assign len_clamped = (family == FAM_IPV4)
                       ? ((prefix_length > IPV4_MAX_LEN) ? IPV4_MAX_LEN : prefix_length)
                       : ((prefix_length > IPV6_MAX_LEN) ? IPV6_MAX_LEN : prefix_length);

    always_comb
    begin
        tbl_wr.v4_en  = in_xfer && (action == ACT_WRITE) && slot_ok && (family == FAM_IPV4);
        tbl_wr.v6_en  = in_xfer && (action == ACT_WRITE) && slot_ok && (family == FAM_IPV6);
        tbl_wr.prefix = {address_high, address_low};
        tbl_wr.len    = len_clamped;
    end

    // last index to scan, count clamped to the table depth
    always_comb
    begin
        cnt_sel = (family == FAM_IPV4) ? v4_cnt_reg : v6_cnt_reg;
        if (LIM_W'(cnt_sel) > LIM_W'(ENTRIES))
        begin
            lim_wide = LIM_W'(ENTRIES - 1);
        end
        else
        begin
            lim_wide = LIM_W'(cnt_sel) - LIM_W'(1);
        end
    end

    // read entry 0 while idle so it is ready on the first scan cycle
    assign rd_addr = (state_reg == ST_SCAN && idx_reg != lim_reg)
                   ? idx_reg + IDX_W'(1) : '0;

    cidr_alm_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .wr_addr  (IDX_W'(entry_index)),
        .rd_addr  (rd_addr),
        .rd_v6    (v6_reg),
        .rd_entry (rd_entry)
    );

    cidr_alm_match u_match (
        .addr  (addr_reg),
        .entry (rd_entry),
        .hit   (hit)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        v4_cnt_next    = v4_cnt_reg;
        v6_cnt_next    = v6_cnt_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        v6_next        = v6_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        res_allow_next = res_allow_reg;
        res_idx_next   = res_idx_reg;
        res_verd_next  = res_verd_reg;
        allowed_next   = allowed_reg;
        match_next     = match_reg;
        verdict_next   = verdict_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IPV4_COUNT: v4_cnt_next = cfg_data;
                CFG_IPV6_COUNT: v6_cnt_next = cfg_data;
                default:        ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_allow_next = 1'b0;
                    res_idx_next   = '0;
                    idx_next       = '0;
                    lim_next       = IDX_W'(lim_wide);
                    v6_next        = (family == FAM_IPV6);
                    if (family == FAM_IPV4)
                    begin
                        addr_next = {address_high[63:32], 96'd0};
                    end
                    else
                    begin
                        addr_next = {address_high, address_low};
                    end
                    if (action == ACT_WRITE)
                    begin
                        res_verd_next = VERDICT_WRITE;
                        state_next    = ST_OUT;
                    end
                    else if ((family != FAM_IPV4 && family != FAM_IPV6) || cnt_sel == '0)
                    begin
                        // unknown family or empty list
                        res_allow_next = 1'b1;
                        res_verd_next  = VERDICT_NO_LIST;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        res_verd_next = VERDICT_DENY;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // one entry compared per cycle, first hit wins
                if (hit)
                begin
                    res_allow_next = 1'b1;
                    res_idx_next   = SLOT_W'(idx_reg);
                    res_verd_next  = VERDICT_MATCH;
                    state_next     = ST_OUT;
                end
                else if (idx_reg == lim_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_OUT:
            begin
                // wait until the output register is free
                if (out_free)
                begin
                    allowed_next   = res_allow_reg;
                    match_next     = res_idx_reg;
                    verdict_next   = res_verd_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v4_cnt_reg    <= CNT_W'(1);
            v6_cnt_reg    <= CNT_W'(1);
            idx_reg       <= '0;
            lim_reg       <= '0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            v4_cnt_reg    <= v4_cnt_next;
            v6_cnt_reg    <= v6_cnt_next;
            idx_reg       <= idx_next;
            lim_reg       <= lim_next;
            v6_reg        <= v6_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        res_allow_reg <= res_allow_next;
        res_idx_reg   <= res_idx_next;
        res_verd_reg  <= res_verd_next;
        allowed_reg   <= allowed_next;
        match_reg     <= match_next;
        verdict_reg   <= verdict_next;
    end

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the cidr allow list matcher: scoreboard, drivers and stimulus
module testbench;
    import cidr_alm_pkg::*;

    localparam int         NUM_SLOTS     = ENTRIES_DEF;
    localparam logic       ACT_CHECK     = 1'b1;
    localparam logic [1:0] FAM_OTHER     = 2'd2;
    localparam logic [1:0] FAM_RESERVED  = 2'd3;
    // random part: segments of one count setting each, four per idle profile
    localparam int         SEGMENTS      = 12;
    localparam int         SEGMENT_ITEMS = 80;
    // long enough to cover the slowest item, a full scan of every entry
    localparam int         SETTLE_CYCLES = 20;
    // cycles without any transfer before the run is declared hung
    localparam int         IDLE_LIMIT    = 5000;
    localparam int         MAX_PRINTED   = 40;

    // one input item as it crosses the input channel
    typedef struct {
        logic              action;
        logic [1:0]        family;
        logic [SLOT_W-1:0] entry_index;
        logic [63:0]       address_high;
        logic [63:0]       address_low;
        logic [LEN_W-1:0]  prefix_length;
    } acl_req_t;

    // one result as it should appear on the result channel
    typedef struct {
        logic              allowed;
        logic [SLOT_W-1:0] match_index;
        verdict_t          verdict;
    } acl_resp_t;

    // shadow copy of both allow lists plus the queue of verdicts still owed
    class acl_scoreboard;
        logic [31:0]      v4_net  [NUM_SLOTS];
        logic [5:0]       v4_bits [NUM_SLOTS];
        logic [127:0]     v6_net  [NUM_SLOTS];
        logic [7:0]       v6_bits [NUM_SLOTS];
        logic [CNT_W-1:0] v4_count;
        logic [CNT_W-1:0] v6_count;
        acl_resp_t        expected_q [$];
        int               mismatches;
        int               checked;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                v4_net[i]  = '0;
                v4_bits[i] = '0;
                v6_net[i]  = '0;
                v6_bits[i] = '0;
            end
            v4_count   = CNT_W'(1);
            v6_count   = CNT_W'(1);
            mismatches = 0;
            checked    = 0;
        endfunction

        static function bit prefix_hit(logic [127:0] addr, logic [127:0] net,
                                       int unsigned len);
            logic [127:0] keep;
            keep = (len == 0) ? '0 : ~128'd0 << (128 - len);
            return ((addr ^ net) & keep) == '0;
        endfunction

        function void set_count(logic [CIDX_W-1:0] idx, logic [CNT_W-1:0] value);
            if (idx == CFG_IPV4_COUNT)
                v4_count = value;
            else if (idx == CFG_IPV6_COUNT)
                v6_count = value;
        endfunction

        function void note_request(acl_req_t req);
            acl_resp_t        exp;
            int unsigned      scan;
            logic [127:0]     addr;
            logic [LEN_W-1:0] len8;
            bit               found;
            bit               hit;
            exp.allowed     = 1'b0;
            exp.match_index = '0;
            exp.verdict     = VERDICT_WRITE;
            addr            = {req.address_high, req.address_low};
            found           = 1'b0;
            if (req.action == ACT_WRITE)
            begin
                if (req.family == FAM_IPV4)
                begin
                    len8 = (req.prefix_length > IPV4_MAX_LEN) ? IPV4_MAX_LEN : req.prefix_length;
                    v4_net[req.entry_index]  = req.address_high[63:32];
                    v4_bits[req.entry_index] = len8[5:0];
                end
                else if (req.family == FAM_IPV6)
                begin
                    len8 = (req.prefix_length > IPV6_MAX_LEN) ? IPV6_MAX_LEN : req.prefix_length;
                    v6_net[req.entry_index]  = addr;
                    v6_bits[req.entry_index] = len8;
                end
            end
            else
            begin
                if (req.family == FAM_IPV4)
                    scan = v4_count;
                else if (req.family == FAM_IPV6)
                    scan = v6_count;
                else
                    scan = 0;
                if (scan > NUM_SLOTS)
                    scan = NUM_SLOTS;
                if (scan == 0)
                begin
                    exp.allowed = 1'b1;
                    exp.verdict = VERDICT_NO_LIST;
                end
                else
                begin
                    exp.verdict = VERDICT_DENY;
                    for (int i = 0; i < scan && !found; i++)
                    begin
                        if (req.family == FAM_IPV4)
                            hit = prefix_hit({req.address_high[63:32], 96'd0},
                                             {v4_net[i], 96'd0}, v4_bits[i]);
                        else
                            hit = prefix_hit(addr, v6_net[i], v6_bits[i]);
                        if (hit)
                        begin
                            found           = 1'b1;
                            exp.allowed     = 1'b1;
                            exp.match_index = SLOT_W'(i);
                            exp.verdict     = VERDICT_MATCH;
                        end
                    end
                end
            end
            expected_q.push_back(exp);
        endfunction

        task flag_mismatch(string what);
            if (mismatches < MAX_PRINTED)
                $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_response(logic allowed_o, logic [SLOT_W-1:0] match_o, logic [1:0] verdict_o);
            acl_resp_t exp;
            if (expected_q.size() == 0)
            begin
                flag_mismatch($sformatf("result with nothing owed: allowed=%0b match=%0d verdict=%0d",
                                        allowed_o, match_o, verdict_o));
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (allowed_o !== exp.allowed)
                flag_mismatch($sformatf("allowed %0b, want %0b", allowed_o, exp.allowed));
            if (match_o !== exp.match_index)
                flag_mismatch($sformatf("match_index %0d, want %0d", match_o, exp.match_index));
            if (verdict_o !== exp.verdict)
                flag_mismatch($sformatf("verdict %0d, want %0d", verdict_o, exp.verdict));
        endtask
    endclass

    // every block input starts from a known value
    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index     = '0;
    logic [CNT_W-1:0]  cfg_data      = '0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic              action        = 1'b0;
    logic [1:0]        family        = '0;
    logic [SLOT_W-1:0] entry_index   = '0;
    logic [63:0]       address_high  = '0;
    logic [63:0]       address_low   = '0;
    logic [LEN_W-1:0]  prefix_length = '0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic              allowed;
    logic [SLOT_W-1:0] match_index;
    logic [1:0]        verdict;

    acl_scoreboard sb;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            sent           = 0;
    int            cfg_writes     = 0;
    int            stuck_cycles   = 0;

    cidr_allow_list_matcher DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side: random stall, one decision per cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // monitor: samples the pre-edge values, so every transfer is seen exactly once
    always @(posedge clk)
    begin : monitor_blk
        acl_req_t seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_response(allowed, match_index, verdict);
            if (in_valid && !in_stall)
            begin
                seen.action        = action;
                seen.family        = family;
                seen.entry_index   = entry_index;
                seen.address_high  = address_high;
                seen.address_low   = address_low;
                seen.prefix_length = prefix_length;
                sb.note_request(seen);
            end
            if (cfg_valid && cfg_ready)
                sb.set_count(cfg_index, cfg_data);
        end
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles, giving up", IDLE_LIMIT);
            $display("cidr_allow_list_matcher regression: fail");
            $finish;
        end
    end

    // one input transfer; valid stays high on return so the next item can follow back to back
    task automatic send_request(acl_req_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= req.action;
        family        <= req.family;
        entry_index   <= req.entry_index;
        address_high  <= req.address_high;
        address_low   <= req.address_low;
        prefix_length <= req.prefix_length;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    // stop sending and wait until every owed verdict has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        // step past a clock edge first so the monitor has logged the last transfer
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both entry counts, back to back on the config channel
    task automatic set_counts(logic [CNT_W-1:0] v4, logic [CNT_W-1:0] v6);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IPV4_COUNT;
        cfg_data  <= v4;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_IPV6_COUNT;
        cfg_data  <= v6;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        cfg_writes += 2;
    endtask

    function automatic acl_req_t make_req(logic act, logic [1:0] fam, logic [SLOT_W-1:0] slot,
                                          logic [63:0] hi, logic [63:0] lo,
                                          logic [LEN_W-1:0] len);
        acl_req_t req;
        req.action        = act;
        req.family        = fam;
        req.entry_index   = slot;
        req.address_high  = hi;
        req.address_low   = lo;
        req.prefix_length = len;
        return req;
    endfunction

    // entry counts: empty list, default, full table, past the table, and in between
    function automatic logic [CNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return CNT_W'(1);
        if (roll < 50)
            return CNT_W'(NUM_SLOTS);
        if (roll < 62)
            return '1;
        if (roll < 75)
            return CNT_W'($urandom_range(30, NUM_SLOTS + 1));
        return CNT_W'($urandom_range(NUM_SLOTS - 1, 2));
    endfunction

    // prefix lengths: catch-all, clamped, full width, and everything in between
    function automatic logic [LEN_W-1:0] pick_length(logic [1:0] fam);
        int unsigned roll;
        int unsigned top;
        roll = $urandom_range(99);
        top  = (fam == FAM_IPV6) ? IPV6_MAX_LEN : IPV4_MAX_LEN;
        if (roll < 6)
            return '0;
        if (roll < 16)
            return LEN_W'($urandom_range(255, top + 1));
        if (roll < 26)
            return LEN_W'(top);
        return LEN_W'($urandom_range(top, 1));
    endfunction

    function automatic acl_req_t random_write(logic [1:0] fam, logic [SLOT_W-1:0] slot);
        return make_req(ACT_WRITE, fam, slot, {$urandom, $urandom}, {$urandom, $urandom},
                        pick_length(fam));
    endfunction

    // random checks: an unknown family, or aimed at a live entry: inside it, one bit outside it, or anywhere
    function automatic acl_req_t random_check();
        acl_req_t     req;
        int unsigned  roll;
        int unsigned  count;
        int unsigned  span;
        int unsigned  slot;
        int unsigned  len;
        logic [127:0] net;
        logic [127:0] keep;
        logic [127:0] addr;
        roll = $urandom_range(99);
        req.action        = ACT_CHECK;
        req.entry_index   = SLOT_W'($urandom);
        req.prefix_length = LEN_W'($urandom);
        if (roll < 8)
            req.family = $urandom_range(1) ? FAM_OTHER : FAM_RESERVED;
        else
            req.family = $urandom_range(1) ? FAM_IPV6 : FAM_IPV4;
        addr  = {$urandom, $urandom, $urandom, $urandom};
        count = (req.family == FAM_IPV4) ? sb.v4_count : sb.v6_count;
        span  = (count == 0) ? 1 : ((count > NUM_SLOTS) ? NUM_SLOTS : count);
        slot  = $urandom_range(span - 1);
        if (req.family == FAM_IPV4)
        begin
            net = {sb.v4_net[slot], 96'd0};
            len = sb.v4_bits[slot];
        end
        else
        begin
            net = sb.v6_net[slot];
            len = sb.v6_bits[slot];
        end
        keep = (len == 0) ? '0 : ~128'd0 << (128 - len);
        if (roll >= 8 && roll < 60)
            addr = (net & keep) | (addr & ~keep);
        else if (roll >= 60 && roll < 80 && len != 0)
            addr = ((net & keep) | (addr & ~keep)) ^ (128'd1 << (127 - $urandom_range(len - 1)));
        req.address_high = addr[127:64];
        req.address_low  = addr[63:0];
        return req;
    endfunction

    // hand-picked items: power-up tables, clamping, other families, every verdict
    task automatic run_directed();
        // power-up tables hold one catch-all entry per family
        send_request(make_req(ACT_CHECK, FAM_IPV4, 0, '0, '0, '0));
        send_request(make_req(ACT_CHECK, FAM_IPV6, 15, '1, '1, '1));
        send_request(make_req(ACT_CHECK, FAM_OTHER, 0, '0, '0, '0));
        send_request(make_req(ACT_CHECK, FAM_RESERVED, 15, '1, '1, '1));
        // stores, lengths past the address width get clamped
        send_request(make_req(ACT_WRITE, FAM_IPV4, 0, 64'hC0A8_0000_DEAD_BEEF, '1, 8'd16));
        send_request(make_req(ACT_WRITE, FAM_IPV4, 1, '1, '0, '1));
        send_request(make_req(ACT_WRITE, FAM_IPV6, 0, '1, '1, 8'd200));
        send_request(make_req(ACT_WRITE, FAM_IPV6, 1, '0, '0, IPV6_MAX_LEN));
        // writes to other families leave the tables alone
        send_request(make_req(ACT_WRITE, FAM_OTHER, 0, '0, '0, '0));
        send_request(make_req(ACT_WRITE, FAM_RESERVED, 15, '1, '1, '1));
        drain_results();
        set_counts(CNT_W'(2), CNT_W'(2));
        // first slot, exact full-width match in the second slot, then a miss
        send_request(make_req(ACT_CHECK, FAM_IPV4, 0, 64'hC0A8_1234_0000_0000, '0, '0));
        send_request(make_req(ACT_CHECK, FAM_IPV4, 0, 64'hFFFF_FFFF_0000_0000, '1, '0));
        send_request(make_req(ACT_CHECK, FAM_IPV4, 0, 64'h0A00_0000_FFFF_FFFF, '1, '0));
        send_request(make_req(ACT_CHECK, FAM_IPV6, 0, '1, '1, '0));
        send_request(make_req(ACT_CHECK, FAM_IPV6, 0, '0, '0, '0));
        send_request(make_req(ACT_CHECK, FAM_IPV6, 0, 64'h8000_0000_0000_0000, '0, '0));
        drain_results();
        // empty ipv4 list, ipv6 count past the table clamps to the table depth
        set_counts('0, '1);
        send_request(make_req(ACT_CHECK, FAM_IPV4, 0, 64'h0A00_0000_0000_0000, '0, '0));
        send_request(make_req(ACT_CHECK, FAM_IPV6, 0, '0, '0, '0));
        send_request(make_req(ACT_CHECK, FAM_IPV6, 0, 64'h2001_0DB8_0000_0000, '1, '0));
        // zero-length prefix in slot zero matches any address
        send_request(make_req(ACT_WRITE, FAM_IPV4, 0, 64'h0102_0304_0506_0708, '0, '0));
        drain_results();
        set_counts(CNT_W'(NUM_SLOTS), CNT_W'(NUM_SLOTS));
        send_request(make_req(ACT_CHECK, FAM_IPV4, 0, 64'hF00D_CAFE_1234_5678, '0, '0));
        drain_results();
    endtask

    // a fill pass over the front of one table, then checks mixed with stray writes
    task automatic run_segment();
        logic [1:0]  fam;
        int unsigned fill;
        fam  = $urandom_range(1) ? FAM_IPV6 : FAM_IPV4;
        fill = $urandom_range(NUM_SLOTS, 4);
        for (int s = 0; s < fill; s++)
            send_request(random_write(fam, SLOT_W'(s)));
        for (int n = 0; n < SEGMENT_ITEMS; n++)
        begin
            if ($urandom_range(99) < 25)
                send_request(random_write(2'($urandom), SLOT_W'($urandom)));
            else
                send_request(random_check());
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // idle profile: slow receiver, then slow sender, then full rate
            case (seg / 4)
                0:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 75;
                end
                1:
                begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 22;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            // counts only change with the block idle
            drain_results();
            set_counts(pick_count(), pick_count());
            run_segment();
        end
        drain_results();
        $display("sent %0d requests, checked %0d verdicts, %0d entry count writes",
                 sent, sb.checked, cfg_writes);
        $display("ran slow-receiver, slow-sender and full-rate traffic over mixed list sizes");
        if (sb.mismatches == 0)
            $display("cidr_allow_list_matcher regression: pass");
        else
            $display("cidr_allow_list_matcher regression: fail");
        $finish;
    end

endmodule
